@@ rtl/otmc_pkg.sv @@
`timescale 1ns / 1ps

package otmc_pkg;

  localparam int COORD_WIDTH_DEFAULT = 16;
  localparam int COUNT_WIDTH_DEFAULT = 16;

  localparam int RATIO_WIDTH = 16;
  localparam int RATIO_FRAC = 14;
  localparam logic [RATIO_WIDTH-1:0] RATIO_RESET = 16'd18063;

  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;
  localparam logic [0:0] REG_RATIO = 1'b0;

  localparam logic [1:0] OUTCOME_SEED = 2'd0;
  localparam logic [1:0] OUTCOME_ASSIGN = 2'd1;
  localparam logic [1:0] OUTCOME_DISCARD = 2'd2;

endpackage

@@ rtl/online_three_means_clusterer.sv @@
`timescale 1ns / 1ps

// Online three-means clusterer for signed fixed-point 2-D points. The first three requests
// seed the three centres with a member count of one and go from acceptance straight to the
// result stage. Every later request is measured by squared distance against all three
// centres; if any two distances lie within the ambiguity ratio (register at byte address 0,
// Q2.14, unsigned) the point is dropped, otherwise the nearest centre moves to its running
// mean and its count grows, saturating. One shared multiplier does the six squares, the six
// ratio partial products and the two centre-times-count products, and a restoring divider
// retires one quotient bit per cycle for each coordinate. point_ready is high only while
// no request is in work and returns in the same cycle that result_valid rises. A finished
// result moves to the output register as soon as that register is free, and holds the block
// busy until then; once there it waits without stopping the next request from being taken.
module online_three_means_clusterer #(
  parameter int COORD_WIDTH = otmc_pkg::COORD_WIDTH_DEFAULT,
  parameter int COUNT_WIDTH = otmc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    point_valid,
  output logic                                    point_ready,
  input  logic signed [COORD_WIDTH-1:0]           point_x,
  input  logic signed [COORD_WIDTH-1:0]           point_y,
  output logic                                    result_valid,
  input  logic                                    result_ready,
  output logic [1:0]                              outcome,
  output logic [1:0]                              cluster,
  output logic signed [COORD_WIDTH-1:0]           new_center_x,
  output logic signed [COORD_WIDTH-1:0]           new_center_y,
  output logic [COUNT_WIDTH-1:0]                  member_count,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [otmc_pkg::APB_ADDR_WIDTH-1:0]     paddr,
  input  logic [otmc_pkg::APB_DATA_WIDTH-1:0]     pwdata,
  output logic [otmc_pkg::APB_DATA_WIDTH-1:0]     prdata,
  output logic                                    pready
);

  localparam int CW = COORD_WIDTH;
  localparam int NW = COUNT_WIDTH;
  localparam int RW = otmc_pkg::RATIO_WIDTH;
  localparam int HW = CW + 1;
  localparam int DW = 2 * HW;
  localparam int PW = DW + RW;
  localparam int MW0 = (HW > RW) ? HW : RW;
  localparam int MW = (MW0 > NW) ? MW0 : NW;
  localparam int AW = (PW > 2 * MW) ? PW : 2 * MW;
  localparam int QW = CW + NW;
  localparam int IW = $clog2(CW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_DSUM,
    S_RLO,
    S_RHI,
    S_RSUM,
    S_CMP,
    S_PICK,
    S_MMUL,
    S_MADD,
    S_DIV,
    S_QSTORE,
    S_DONE
  } state_t;

  state_t state;

  logic [CW-1:0]   center_x [3];
  logic [CW-1:0]   center_y [3];
  logic [NW-1:0]   counts [3];
  logic [1:0]      seeded;
  logic [RW-1:0]   ratio;

  logic [CW-1:0]   px;
  logic [CW-1:0]   py;
  logic [1:0]      k;
  logic [1:0]      j;
  logic [1:0]      kind;
  logic            coord;
  logic [HW-1:0]   ax;
  logic [HW-1:0]   ay;
  logic [2*MW-1:0] prod;
  logic [AW-1:0]   acc;
  logic [DW-1:0]   dsq [3];
  logic [PW-1:0]   rdist [3];
  logic [2:0]      lt_flags;
  logic            amb_any;
  logic            neg;
  logic [NW-1:0]   rem;
  logic [CW-1:0]   qsh;
  logic [NW:0]     divisor;
  logic [IW-1:0]   iter;
  logic [CW-1:0]   qx;
  logic [CW-1:0]   qy;

  logic [MW-1:0]   mul_a;
  logic [MW-1:0]   mul_b;
  logic [2*MW-1:0] mul_p;
  logic [HW-1:0]   dx;
  logic [HW-1:0]   dy;
  logic [HW-1:0]   ax_c;
  logic [HW-1:0]   ay_c;
  logic [DW-1:0]   dist_k;
  logic [DW-1:0]   pa;
  logic [DW-1:0]   pb;
  logic [PW-1:0]   pra;
  logic [PW-1:0]   prb;
  logic            lt_now;
  logic            amb_now;
  logic [PW-1:0]   big_sh;
  logic [1:0]      k_pick;
  logic [CW-1:0]   csel;
  logic [CW-1:0]   cmag;
  logic [CW-1:0]   pcoord;
  logic [QW:0]     pv;
  logic [QW:0]     num;
  logic [QW:0]     nabs;
  logic [NW:0]     sh;
  logic            ge;
  logic [NW:0]     diff;
  logic [CW-1:0]   qval;
  logic [NW-1:0]   count_k;
  logic [NW-1:0]   count_inc;
  logic            out_free;
  logic            cfg_write;

  assign pready = 1'b1;
  assign point_ready = (state == S_IDLE);
  assign out_free = !result_valid || result_ready;
  assign cfg_write = psel && penable && pwrite
                     && (paddr[otmc_pkg::APB_ADDR_WIDTH-1:2] == otmc_pkg::REG_RATIO);
  assign prdata = (paddr[otmc_pkg::APB_ADDR_WIDTH-1:2] == otmc_pkg::REG_RATIO)
                  ? otmc_pkg::APB_DATA_WIDTH'(ratio) : '0;

  always_comb begin
    dist_k = dsq[k];
    count_k = counts[k];
    count_inc = (&count_k) ? count_k : NW'(count_k + 1'b1);

    dx = {px[CW-1], px} - {center_x[k][CW-1], center_x[k]};
    dy = {py[CW-1], py} - {center_y[k][CW-1], center_y[k]};
    ax_c = dx[HW-1] ? HW'(-dx) : dx;
    ay_c = dy[HW-1] ? HW'(-dy) : dy;

    csel = coord ? center_y[k] : center_x[k];
    cmag = csel[CW-1] ? CW'(-csel) : csel;
    pcoord = coord ? py : px;

    unique case (state)
      S_SQX: begin
        mul_a = MW'(ax);
        mul_b = MW'(ax);
      end
      S_SQY: begin
        mul_a = MW'(ay);
        mul_b = MW'(ay);
      end
      S_RLO: begin
        mul_a = MW'(ratio);
        mul_b = MW'(dist_k[HW-1:0]);
      end
      S_RHI: begin
        mul_a = MW'(ratio);
        mul_b = MW'(dist_k[DW-1:HW]);
      end
      S_MMUL: begin
        mul_a = MW'(cmag);
        mul_b = MW'(count_k);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = (2 * MW)'(mul_a) * (2 * MW)'(mul_b);

    unique case (j)
      2'd0: begin
        pa = dsq[0];
        pb = dsq[1];
        pra = rdist[0];
        prb = rdist[1];
      end
      2'd1: begin
        pa = dsq[0];
        pb = dsq[2];
        pra = rdist[0];
        prb = rdist[2];
      end
      default: begin
        pa = dsq[1];
        pb = dsq[2];
        pra = rdist[1];
        prb = rdist[2];
      end
    endcase
    lt_now = pa < pb;
    big_sh = PW'(lt_now ? pb : pa) << otmc_pkg::RATIO_FRAC;
    amb_now = (pa == pb) || (big_sh <= (lt_now ? pra : prb));

    if (lt_flags[0] && lt_flags[1]) begin
      k_pick = 2'd0;
    end else if (lt_flags[2]) begin
      k_pick = 2'd1;
    end else begin
      k_pick = 2'd2;
    end

    pv = {1'b0, prod[QW-1:0]};
    num = (csel[CW-1] ? (QW + 1)'(-pv) : pv) + {{(QW + 1 - CW){pcoord[CW-1]}}, pcoord};
    nabs = num[QW] ? (QW + 1)'(-num) : num;

    sh = {rem, qsh[CW-1]};
    ge = sh >= divisor;
    diff = sh - divisor;

    qval = neg ? CW'(-qsh) : qsh;
  end

  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      seeded <= 2'd0;
      ratio <= otmc_pkg::RATIO_RESET;
      for (int i = 0; i < 3; i++) begin
        center_x[i] <= '0;
        center_y[i] <= '0;
        counts[i] <= '0;
      end
    end else begin
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (cfg_write) begin
        ratio <= pwdata[RW-1:0];
      end

      unique case (state)
        S_IDLE: begin
          if (point_valid) begin
            px <= point_x;
            py <= point_y;
            if (seeded != 2'd3) begin
              k <= seeded;
              kind <= otmc_pkg::OUTCOME_SEED;
              state <= S_DONE;
            end else begin
              k <= 2'd0;
              state <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          ax <= ax_c;
          ay <= ay_c;
          state <= S_SQX;
        end
        S_SQX: begin
          state <= S_SQY;
        end
        S_SQY: begin
          acc <= AW'(prod);
          state <= S_DSUM;
        end
        S_DSUM: begin
          dsq[k] <= DW'(acc + AW'(prod));
          if (k == 2'd2) begin
            k <= 2'd0;
            state <= S_RLO;
          end else begin
            k <= k + 2'd1;
            state <= S_DIFF;
          end
        end
        S_RLO: begin
          state <= S_RHI;
        end
        S_RHI: begin
          acc <= AW'(prod);
          state <= S_RSUM;
        end
        S_RSUM: begin
          rdist[k] <= PW'(acc + (AW'(prod) << HW));
          if (k == 2'd2) begin
            j <= 2'd0;
            amb_any <= 1'b0;
            state <= S_CMP;
          end else begin
            k <= k + 2'd1;
            state <= S_RLO;
          end
        end
        S_CMP: begin
          lt_flags[j] <= lt_now;
          amb_any <= amb_any || amb_now;
          if (j == 2'd2) begin
            if (amb_any || amb_now) begin
              kind <= otmc_pkg::OUTCOME_DISCARD;
              state <= S_DONE;
            end else begin
              state <= S_PICK;
            end
          end else begin
            j <= j + 2'd1;
          end
        end
        S_PICK: begin
          k <= k_pick;
          coord <= 1'b0;
          kind <= otmc_pkg::OUTCOME_ASSIGN;
          state <= S_MMUL;
        end
        S_MMUL: begin
          state <= S_MADD;
        end
        S_MADD: begin
          neg <= num[QW];
          rem <= nabs[QW-1:CW];
          qsh <= nabs[CW-1:0];
          divisor <= {1'b0, count_k} + 1'b1;
          iter <= IW'(CW - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? diff[NW-1:0] : sh[NW-1:0];
          qsh <= {qsh[CW-2:0], ge};
          if (iter == '0) begin
            state <= S_QSTORE;
          end else begin
            iter <= iter - 1'b1;
          end
        end
        S_QSTORE: begin
          if (!coord) begin
            qx <= qval;
            coord <= 1'b1;
            state <= S_MMUL;
          end else begin
            qy <= qval;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            outcome <= kind;
            state <= S_IDLE;
            unique case (kind)
              otmc_pkg::OUTCOME_SEED: begin
                center_x[k] <= px;
                center_y[k] <= py;
                counts[k] <= NW'(1);
                seeded <= seeded + 2'd1;
                cluster <= k;
                new_center_x <= px;
                new_center_y <= py;
                member_count <= NW'(1);
              end
              otmc_pkg::OUTCOME_ASSIGN: begin
                center_x[k] <= qx;
                center_y[k] <= qy;
                counts[k] <= count_inc;
                cluster <= k;
                new_center_x <= qx;
                new_center_y <= qy;
                member_count <= count_inc;
              end
              default: begin
                cluster <= 2'd0;
                new_center_x <= '0;
                new_center_y <= '0;
                member_count <= '0;
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
